/* src/ntd_pkg.sv */
package ntd_pkg;

  localparam int unsigned NAME_W          = 64;
  localparam int unsigned SLOT_W          = 4;
  localparam int unsigned DEF_MAX_ENTRIES = 16;
  localparam int unsigned MAX_RESULTS     = 16;

  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;
  localparam logic [1:0] REQ_LIST   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef logic [1:0] cell_op_t;

  localparam cell_op_t OP_HOLD = 2'd0;
  localparam cell_op_t OP_KEY  = 2'd1;
  localparam cell_op_t OP_NEXT = 2'd2;
  localparam cell_op_t OP_HEAD = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [NAME_W-1:0] key_name;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic [NAME_W-1:0] entry_name;
    logic              last_result;
  } rsp_t;

endpackage

/* src/ntd_cell.sv */
module ntd_cell (
  input  logic                         clk,
  input  ntd_pkg::cell_op_t            op,
  input  logic [ntd_pkg::NAME_W-1:0]   key,
  input  logic [ntd_pkg::NAME_W-1:0]   next_name,
  input  logic [ntd_pkg::NAME_W-1:0]   head_name,
  output logic [ntd_pkg::NAME_W-1:0]   name,
  output logic                         match
);
  import ntd_pkg::*;

  always_ff @(posedge clk) begin
    case (op)
      OP_KEY:  name <= key;
      OP_NEXT: name <= next_name;
      OP_HEAD: name <= head_name;
      default: name <= name;
    endcase
  end

  assign match = (name == key);

endmodule

/* src/name_table_insert_delete_search_unit.sv */
// Name table: up to MAX_ENTRIES names of 64 bits held in a row of cells.
// Request channel (req_valid / req_stall / req) carries one beat per request;
// result channel (rsp_valid / rsp_stall / rsp) carries one or more beats back.
// The block handles one request at a time and stalls the request channel
// until the previous request has finished its work.
// Create, delete and search go through these steps in order: latch the
// request, let every cell compare its name against the key, encode the
// first match, then apply the update and load the result register once
// the result channel is free. A list request then walks the table by
// rotating the row of cells one position a cycle through cell 0 unless the
// result channel stalls, one step per stored entry, and leaves the row in
// its original order. At most 16 entries are reported, the last one marked.
// A stall on the result channel freezes the walk while entries remain to be
// reported, and holds the result beat.
// Reset empties the table (fill count zero), drops any pending result and
// holds the request channel stalled while it lasts.
module name_table_insert_delete_search_unit #(
  parameter int unsigned MAX_ENTRIES = ntd_pkg::DEF_MAX_ENTRIES
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ntd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ntd_pkg::rsp_t rsp
);
  import ntd_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW  = $clog2(MAX_ENTRIES);
  localparam int unsigned LIM = (MAX_ENTRIES < MAX_RESULTS) ? MAX_ENTRIES : MAX_RESULTS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_ENC  = 3'd2;
  localparam logic [2:0] S_DO   = 3'd3;
  localparam logic [2:0] S_LIST = 3'd4;

  logic [2:0]             state;
  logic [1:0]             req_type;
  logic [NAME_W-1:0]      key;
  logic [CW-1:0]          fill;
  logic [CW-1:0]          cnt;
  logic [MAX_ENTRIES-1:0] hit_vec;
  logic                   found;
  logic [IW-1:0]          idx;

  logic [NAME_W-1:0]      names     [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_hits;
  cell_op_t               ops       [MAX_ENTRIES];

  logic                   out_free;
  logic                   full;
  logic                   list_emit;
  logic                   list_step;
  logic                   list_last;
  logic                   rsp_load;
  logic [CW-1:0]          cnt_inc;
  logic                   enc_found;
  logic [IW-1:0]          enc_idx;
  logic [IW+SLOT_W-1:0]   idx_ext;
  logic [IW+SLOT_W-1:0]   cnt_ext;
  logic [CW+SLOT_W-1:0]   fill_ext;

  assign req_stall = rst || (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign full      = (fill == CW'(MAX_ENTRIES));
  assign cnt_inc   = cnt + CW'(1);
  assign list_emit = (cnt < CW'(LIM));
  assign list_step = (state == S_LIST) && (!list_emit || out_free);
  assign list_last = (cnt_inc == fill) || (cnt_inc == CW'(LIM));
  assign idx_ext   = {{SLOT_W{1'b0}}, idx};
  assign cnt_ext   = {{SLOT_W{1'b0}}, cnt[IW-1:0]};
  assign fill_ext  = {{SLOT_W{1'b0}}, fill};

  // A beat is loaded when a single-result request finishes or the walk emits one.
  assign rsp_load = ((state == S_DO) && out_free && !(req_type == REQ_LIST && fill != '0)) ||
                    (list_step && list_emit);

  // First match wins: scan from the top so the lowest index is left.
  always_comb begin
    enc_found = 1'b0;
    enc_idx   = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        enc_found = 1'b1;
        enc_idx   = IW'(i);
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      localparam logic [CW-1:0] POS  = CW'(g);
      localparam logic [CW-1:0] POS1 = CW'(g + 1);
      logic [NAME_W-1:0] next_name;

      if (g == MAX_ENTRIES - 1) begin : g_tail
        assign next_name = '0;
      end else begin : g_mid
        assign next_name = names[g + 1];
      end

      always_comb begin
        ops[g] = OP_HOLD;
        if (state == S_DO && out_free) begin
          if (req_type == REQ_CREATE && !full && fill == POS) begin
            ops[g] = OP_KEY;
          end else if (req_type == REQ_DELETE && found && POS >= CW'(idx) && POS1 < fill) begin
            ops[g] = OP_NEXT;
          end
        end else if (list_step) begin
          if (POS1 < fill) begin
            ops[g] = OP_NEXT;
          end else if (POS1 == fill) begin
            ops[g] = OP_HEAD;
          end
        end
      end

      ntd_cell u_cell (
        .clk       (clk),
        .op        (ops[g]),
        .key       (key),
        .next_name (next_name),
        .head_name (names[0]),
        .name      (names[g]),
        .match     (cell_hits[g])
      );

      always_ff @(posedge clk) begin
        if (state == S_CMP) begin
          hit_vec[g] <= cell_hits[g] && (POS < fill);
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_type <= req.req_type;
      key      <= req.key_name;
    end
    if (state == S_ENC) begin
      found <= enc_found;
      idx   <= enc_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_load || (rsp_valid && rsp_stall);
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_ENC;
        end
        S_ENC: begin
          state <= S_DO;
        end
        S_DO: begin
          if (out_free) begin
            rsp.entry_name  <= '0;
            rsp.last_result <= 1'b1;
            case (req_type)
              REQ_CREATE: begin
                state <= S_IDLE;
                if (full) begin
                  rsp.status     <= ST_FULL;
                  rsp.slot_index <= '0;
                end else begin
                  rsp.status     <= ST_OK;
                  rsp.slot_index <= fill_ext[SLOT_W-1:0];
                  fill           <= fill + CW'(1);
                end
              end
              REQ_DELETE, REQ_SEARCH: begin
                state <= S_IDLE;
                if (found) begin
                  rsp.status     <= ST_OK;
                  rsp.slot_index <= idx_ext[SLOT_W-1:0];
                  if (req_type == REQ_DELETE) begin
                    fill <= fill - CW'(1);
                  end
                end else begin
                  rsp.status     <= ST_NOT_FOUND;
                  rsp.slot_index <= '0;
                end
              end
              default: begin
                rsp.status     <= ST_EMPTY;
                rsp.slot_index <= '0;
                if (fill == '0) begin
                  state <= S_IDLE;
                end else begin
                  cnt   <= '0;
                  state <= S_LIST;
                end
              end
            endcase
          end
        end
        S_LIST: begin
          if (list_step) begin
            if (list_emit) begin
              rsp.status      <= ST_OK;
              rsp.slot_index  <= cnt_ext[SLOT_W-1:0];
              rsp.entry_name  <= names[0];
              rsp.last_result <= list_last;
            end
            cnt <= cnt_inc;
            if (cnt_inc == fill) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
